// ===== sv/i2cme_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cme_pkg
// Shared types and codes for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cme_pkg;

  // Request / active command codes
  localparam logic [2:0] CMD_IDLE  = 3'd0;   // on input: a timing tick
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // Phase landmarks within a byte command
  localparam logic [4:0] PH_ZERO     = 5'd0;
  localparam logic [4:0] PH_ONE      = 5'd1;
  localparam logic [4:0] PH_DATA_END = 5'd16;
  localparam logic [4:0] PH_ACK      = 5'd17;
  localparam logic [4:0] PH_POLL     = 5'd18;
  localparam logic [4:0] PH_LAST     = 5'd19;

  localparam logic [7:0] ACK_LIMIT_RST = 8'd8;
  localparam logic [7:0] BYTE_MSB      = 8'h80;
  localparam logic [7:0] POLL_STEP     = 8'h01;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       no_ack;
  } res_t;

endpackage

// ===== sv/i2c_master_byte_engine.sv =====
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master line sequencer driven by command and tick transfers.
// ----------------------------------------------------------------------------
// Every input transfer is either a command (start, stop, write byte, read
// byte) or a timing tick carrying the sampled SDA level; every input transfer
// yields exactly one result transfer with the SCL/SDA levels to drive, busy,
// done, the last received byte and the no_ack flag. Each tick advances one
// half-bit phase: a start or stop takes 3 ticks, a write 18 ticks plus the
// acknowledge poll (up to the ack_poll_limit register), a read 20 ticks.
// Commands arriving while a command is in progress, and unknown codes, are
// dropped (they still return a result). The block takes one transfer per
// clock while the result side is not stalled; a transfer passes an input
// register and then a result register, which is loaded only when it has
// room. Write ack_poll_limit only while idle.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine import i2cme_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] tx_byte, [8] send_ack, [9] sda_in, rest zero
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] scl_out, [1] sda_out, [2] sda_drive,
                                  // [3] busy_res, [4] done_res, [12:5] rx_byte,
                                  // [13] no_ack, rest zero
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  req_t in_req;
  req_t req;
  res_t res;
  res_t res_q;
  logic req_valid;
  logic out_space;
  logic step_en;

  // Unpack the request transfer
  assign in_req.req_type = in_tuser;
  assign in_req.tx_byte  = in_tdata[7:0];
  assign in_req.send_ack = in_tdata[8];
  assign in_req.sda_in   = in_tdata[9];

  // Advance the held request whenever the result register has room
  assign step_en = req_valid && out_space;

  i2cme_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (in_req),
    .req_valid (req_valid),
    .req_take  (out_space),
    .req       (req)
  );

  i2cme_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step_en     (step_en),
    .req         (req),
    .res         (res)
  );

  i2cme_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en),
    .res_in    (res),
    .space     (out_space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_out   (res_q)
  );

  // Pack the result transfer, lowest field first
  assign out_tdata = {2'b00, res_q.no_ack, res_q.rx_byte, res_q.done_res,
                      res_q.busy_res, res_q.sda_drive, res_q.sda_out,
                      res_q.scl_out};

endmodule

// ===== sv/i2cme_in_stage.sv =====
// ----------------------------------------------------------------------------
// i2cme_in_stage
// Input register: captures one request transfer and holds it until the
// sequencer takes it.
// ----------------------------------------------------------------------------
module i2cme_in_stage import i2cme_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic req_valid,
  input  logic req_take,
  output req_t req
);

  logic valid_r;
  logic valid_nxt;
  req_t req_r;

  assign in_ready  = !valid_r || req_take;
  assign req_valid = valid_r;
  assign req       = req_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_req;
    end
  end

endmodule

// ===== sv/i2cme_seq.sv =====
// ----------------------------------------------------------------------------
// i2cme_seq
// Line sequencer: bus state registers and the one-step update for a request.
// ----------------------------------------------------------------------------
module i2cme_seq import i2cme_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       step_en,
  input  req_t       req,
  output res_t       res
);

  logic [7:0] limit_r;
  logic [2:0] cmd_r,   cmd_nxt;
  logic [4:0] phase_r, phase_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] poll_r,  poll_nxt;
  logic       scl_r,   scl_nxt;
  logic       sda_r,   sda_nxt;
  logic       drv_r,   drv_nxt;
  logic       ackc_r,  ackc_nxt;
  logic       err_r,   err_nxt;
  logic [7:0] rx_r,    rx_nxt;
  logic       done;
  logic [7:0] poll_inc;
  logic [7:0] shift_in;

  assign poll_inc = poll_r + POLL_STEP;
  assign shift_in = {shift_r[6:0], req.sda_in};

  always_comb begin
    cmd_nxt   = cmd_r;
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    poll_nxt  = poll_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    drv_nxt   = drv_r;
    ackc_nxt  = ackc_r;
    err_nxt   = err_r;
    rx_nxt    = rx_r;
    done      = 1'b0;
    if (req.req_type == CMD_IDLE) begin
      unique case (cmd_r)
        CMD_START: begin
          if (phase_r == PH_ZERO) begin
            drv_nxt = 1'b1; scl_nxt = 1'b1; sda_nxt = 1'b1;
          end else if (phase_r == PH_ONE) begin
            sda_nxt = 1'b0;
          end else begin
            scl_nxt = 1'b0; done = 1'b1;
          end
        end
        CMD_STOP: begin
          if (phase_r == PH_ZERO) begin
            scl_nxt = 1'b0; drv_nxt = 1'b1; sda_nxt = 1'b0;
          end else if (phase_r == PH_ONE) begin
            scl_nxt = 1'b1;
          end else begin
            sda_nxt = 1'b1; done = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (phase_r < PH_DATA_END) begin
            if (!phase_r[0]) begin
              scl_nxt = 1'b0; drv_nxt = 1'b1;
              sda_nxt = |(shift_r & BYTE_MSB);
            end else begin
              scl_nxt   = 1'b1;
              shift_nxt = {shift_r[6:0], 1'b0};
            end
          end else if (phase_r == PH_DATA_END) begin
            scl_nxt = 1'b0; drv_nxt = 1'b0;
          end else if (phase_r == PH_ACK) begin
            scl_nxt = 1'b1;
          end else if (!req.sda_in) begin
            scl_nxt = 1'b0; drv_nxt = 1'b1; sda_nxt = 1'b1; done = 1'b1;
          end else begin
            poll_nxt = poll_inc;
            if (poll_inc >= limit_r) begin
              err_nxt = 1'b1;
              scl_nxt = 1'b0; drv_nxt = 1'b1; sda_nxt = 1'b1; done = 1'b1;
            end
          end
        end
        CMD_READ: begin
          if (phase_r == PH_ZERO) begin
            scl_nxt = 1'b0; drv_nxt = 1'b0;
          end else if (phase_r <= PH_DATA_END) begin
            if (phase_r[0]) begin
              scl_nxt = 1'b1;
            end else begin
              shift_nxt = shift_in;
              scl_nxt   = 1'b0;
              if (phase_r == PH_DATA_END) begin
                rx_nxt = shift_in;
              end
            end
          end else if (phase_r == PH_ACK) begin
            scl_nxt = 1'b0; drv_nxt = 1'b1; sda_nxt = !ackc_r;
          end else if (phase_r == PH_POLL) begin
            scl_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b0; done = 1'b1;
          end
        end
        default: begin
          // idle: a tick changes nothing
        end
      endcase
      if (done) begin
        cmd_nxt   = CMD_IDLE;
        phase_nxt = PH_ZERO;
      end else if (cmd_r != CMD_IDLE &&
                   (phase_r < PH_POLL || cmd_r != CMD_WRITE)) begin
        phase_nxt = phase_r + PH_ONE;
      end
    end else if (req.req_type <= CMD_READ && cmd_r == CMD_IDLE) begin
      cmd_nxt   = req.req_type;
      phase_nxt = PH_ZERO;
      poll_nxt  = '0;
      if (req.req_type == CMD_WRITE) begin
        shift_nxt = req.tx_byte;
        err_nxt   = 1'b0;
      end else if (req.req_type == CMD_READ) begin
        shift_nxt = '0;
        ackc_nxt  = req.send_ack;
      end
    end
  end

  always_comb begin
    res.scl_out   = scl_nxt;
    res.sda_out   = sda_nxt;
    res.sda_drive = drv_nxt;
    res.busy_res  = (cmd_nxt != CMD_IDLE);
    res.done_res  = done;
    res.rx_byte   = rx_nxt;
    res.no_ack    = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= ACK_LIMIT_RST;
      cmd_r   <= CMD_IDLE;
      phase_r <= PH_ZERO;
      shift_r <= '0;
      poll_r  <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      drv_r   <= 1'b1;
      ackc_r  <= 1'b0;
      err_r   <= 1'b0;
      rx_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (step_en) begin
        cmd_r   <= cmd_nxt;
        phase_r <= phase_nxt;
        shift_r <= shift_nxt;
        poll_r  <= poll_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        drv_r   <= drv_nxt;
        ackc_r  <= ackc_nxt;
        err_r   <= err_nxt;
        rx_r    <= rx_nxt;
      end
    end
  end

  // Idle engine always sits at phase zero
  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_r == CMD_IDLE) |-> (phase_r == PH_ZERO))
    else $error("idle with nonzero phase");

  // Phase never runs past the last read phase
  a_phase_max: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_LAST)
    else $error("phase out of range");

  // A finished command always leaves the engine idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && done) |=> (cmd_r == CMD_IDLE))
    else $error("done but still busy");

  // no_ack only rises at the end of a write
  a_err_rise: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && !err_r && err_nxt) |-> (done && cmd_r == CMD_WRITE))
    else $error("no_ack set outside write completion");

endmodule

// ===== sv/i2cme_out_stage.sv =====
// ----------------------------------------------------------------------------
// i2cme_out_stage
// Result register: holds one result transfer until the consumer takes it.
// ----------------------------------------------------------------------------
module i2cme_out_stage import i2cme_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res_in,
  output logic space,
  output logic out_valid,
  input  logic out_ready,
  output res_t res_out
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C master byte engine.
// ----------------------------------------------------------------------------
// Drives start, stop, write and read sequences, made of one command transfer
// followed by tick transfers, through the input stream. A line scoreboard
// tracks the sequencer state and predicts the SCL/SDA levels, busy, done,
// rx_byte and no_ack of every result transfer, in order. A directed part
// covers the boundary cases. Random sequences with stray commands and
// unknown codes follow under several ack_poll_limit settings.
// ----------------------------------------------------------------------------
import i2cme_pkg::*;

class line_scoreboard;
  logic [7:0] poll_limit;
  logic [2:0] cmd;
  logic [4:0] phase;
  logic [3:0] bits;
  logic [7:0] shreg;
  logic [7:0] misses;
  logic       scl, sda, drv;
  logic       ack_sel;
  logic       err;
  logic [7:0] rx_hold;
  res_t       line_q[$];
  int         errors;
  int         transfers;
  int         results;
  int         started[8];
  int         nacked_writes;

  function new();
    poll_limit = ACK_LIMIT_RST;
    cmd        = CMD_IDLE;
    phase      = PH_ZERO;
    bits       = '0;
    shreg      = '0;
    misses     = '0;
    scl        = 1'b1;
    sda        = 1'b1;
    drv        = 1'b1;
    ack_sel    = 1'b0;
    err        = 1'b0;
    rx_hold    = '0;
    errors     = 0;
    transfers  = 0;
    results    = 0;
    nacked_writes = 0;
    foreach (started[i]) started[i] = 0;
  endfunction

  function void set_limit(logic [7:0] v);
    poll_limit = v;
  endfunction

  function bit busy();
    return cmd != CMD_IDLE;
  endfunction

  function int pending();
    return line_q.size();
  endfunction

  // Advance the active command by one half-bit phase; return 1 when it ends.
  function bit advance_phase(logic sda_in);
    bit fin;
    fin = 1'b0;
    case (cmd)
      CMD_START: begin
        if (phase == PH_ZERO) begin
          drv = 1'b1; scl = 1'b1; sda = 1'b1;
        end else if (phase == PH_ONE) begin
          sda = 1'b0;
        end else begin
          scl = 1'b0; fin = 1'b1;
        end
      end
      CMD_STOP: begin
        if (phase == PH_ZERO) begin
          scl = 1'b0; drv = 1'b1; sda = 1'b0;
        end else if (phase == PH_ONE) begin
          scl = 1'b1;
        end else begin
          sda = 1'b1; fin = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (phase < PH_DATA_END) begin
          if (!phase[0]) begin
            scl = 1'b0; drv = 1'b1; sda = shreg[7];
          end else begin
            scl = 1'b1; shreg = {shreg[6:0], 1'b0}; bits = bits + 4'd1;
          end
        end else if (phase == PH_DATA_END) begin
          scl = 1'b0; drv = 1'b0;
        end else if (phase == PH_ACK) begin
          scl = 1'b1;
        end else if (!sda_in) begin
          scl = 1'b0; drv = 1'b1; sda = 1'b1; fin = 1'b1;
        end else begin
          misses = misses + POLL_STEP;
          // a limit of zero behaves as one: the first miss ends the write
          if (misses >= poll_limit) begin
            err = 1'b1; scl = 1'b0; drv = 1'b1; sda = 1'b1; fin = 1'b1;
            nacked_writes++;
          end
        end
      end
      default: begin
        if (phase == PH_ZERO) begin
          scl = 1'b0; drv = 1'b0;
        end else if (phase <= PH_DATA_END) begin
          if (phase[0]) begin
            scl = 1'b1;
          end else begin
            shreg = {shreg[6:0], sda_in};
            bits  = bits + 4'd1;
            scl   = 1'b0;
            if (phase == PH_DATA_END) rx_hold = shreg;
          end
        end else if (phase == PH_ACK) begin
          scl = 1'b0; drv = 1'b1; sda = (ack_sel == 1'b0);
        end else if (phase == PH_POLL) begin
          scl = 1'b1;
        end else begin
          scl = 1'b0; fin = 1'b1;
        end
      end
    endcase
    return fin;
  endfunction

  // Note an accepted input transfer and queue the line state it produces.
  function void note_transfer(req_t r);
    bit   fin;
    res_t want;
    fin = 1'b0;
    transfers++;
    if (r.req_type == CMD_IDLE) begin
      if (cmd != CMD_IDLE) begin
        fin = advance_phase(r.sda_in);
        if (fin) begin
          cmd   = CMD_IDLE;
          phase = PH_ZERO;
        end else if (phase < PH_POLL || cmd != CMD_WRITE) begin
          phase = phase + 5'd1;
        end
      end
    end else if (r.req_type <= CMD_READ && cmd == CMD_IDLE) begin
      cmd    = r.req_type;
      phase  = PH_ZERO;
      bits   = '0;
      misses = '0;
      started[cmd]++;
      if (r.req_type == CMD_WRITE) begin
        shreg = r.tx_byte;
        err   = 1'b0;
      end else if (r.req_type == CMD_READ) begin
        shreg   = '0;
        ack_sel = r.send_ack;
      end
    end
    want.scl_out   = scl;
    want.sda_out   = sda;
    want.sda_drive = drv;
    want.busy_res  = (cmd != CMD_IDLE);
    want.done_res  = fin;
    want.rx_byte   = rx_hold;
    want.no_ack    = err;
    line_q.push_back(want);
  endfunction

  function void compare_field(string nm, int want, int got);
    if (want != got) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, nm, want, got);
    end
  endfunction

  // Check one result transfer against the oldest prediction.
  function void check_result(logic [15:0] d);
    res_t want;
    results++;
    if (line_q.size() == 0) begin
      errors++;
      if (errors <= 40)
        $display("%0t: unexpected result, expected none, actual 0x%04h", $time, d);
      return;
    end
    want = line_q.pop_front();
    compare_field("scl_out",   int'(want.scl_out),   int'(d[0]));
    compare_field("sda_out",   int'(want.sda_out),   int'(d[1]));
    compare_field("sda_drive", int'(want.sda_drive), int'(d[2]));
    compare_field("busy_res",  int'(want.busy_res),  int'(d[3]));
    compare_field("done_res",  int'(want.done_res),  int'(d[4]));
    compare_field("rx_byte",   int'(want.rx_byte),   int'(d[12:5]));
    compare_field("no_ack",    int'(want.no_ack),    int'(d[13]));
    compare_field("padding",   0,                    int'(d[15:14]));
  endfunction
endclass

module tb;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int NEVER_ACK    = 100000;  // poll count that is never reached
  localparam int ITEMS_TARGET = 600;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] tx_byte, [8] send_ack, [9] sda_in, rest zero
  logic [2:0]  in_tuser;   // [2:0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [0] scl_out, [1] sda_out, [2] sda_drive, [3] busy_res,
                           // [4] done_res, [12:5] rx_byte, [13] no_ack, rest zero
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;

  line_scoreboard sb;
  int             cycles;
  int             burst_left;
  int             stall_mode;
  int             stall_left;

  i2c_master_byte_engine u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // 2 ns clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("i2c_master_byte_engine test failed");
      $finish;
    end
  end

  // Result side: check every transfer, then pick next cycle's tready from
  // a stall pattern whose mode is redrawn when its random hold count runs out.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;                        // stream freely
      1:       out_tready <= ($urandom_range(0, 3) != 0); // light back-pressure
      2:       out_tready <= (cycles % 9) < 3;            // long periodic stalls
      default: out_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  function automatic req_t make_req(logic [2:0] op, logic [7:0] data, logic ack,
                                    logic sda_bit);
    req_t r;
    r.req_type = op;
    r.tx_byte  = data;
    r.send_ack = ack;
    r.sda_in   = sda_bit;
    return r;
  endfunction

  // Random filler for the fields that a tick or a stray command ignores.
  function automatic req_t random_req(logic [2:0] op);
    return make_req(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
  endfunction

  // Present one transfer and hold it until accepted. Bursts of back-to-back
  // transfers alternate with random gaps.
  task automatic push_item(input req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.req_type;
    in_tdata  <= {6'b0, r.sda_in, r.send_ack, r.tx_byte};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_transfer(r);
    burst_left--;
  endtask

  // Issue a command while idle and tick it to completion. In the poll phase
  // of a write, SDA stays high for ack_after samples, then acknowledges.
  // Stray commands land in the middle with the given percentage.
  task automatic run_command(input logic [2:0] op, input logic [7:0] data, input logic ack,
                             input int ack_after, input int noise_pct);
    int   missed;
    req_t r;
    missed = 0;
    push_item(make_req(op, data, ack, 1'($urandom_range(0, 1))));
    while (sb.busy()) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        push_item(random_req(3'($urandom_range(CMD_START, 7))));
      end else begin
        r = random_req(CMD_IDLE);
        if (sb.cmd == CMD_WRITE && sb.phase == PH_POLL) begin
          r.sda_in = (missed >= ack_after) ? 1'b0 : 1'b1;
          missed++;
        end
        push_item(r);
      end
    end
  endtask

  // Let every outstanding result arrive, then write the poll limit.
  task automatic quiesce_and_set_limit(input logic [7:0] v);
    in_tvalid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_limit(v);
  endtask

  task automatic directed_checks();
    // tick while idle and unknown codes: no change of state
    push_item(random_req(CMD_IDLE));
    for (int c = CMD_READ + 1; c <= 7; c++) push_item(random_req(c[2:0]));
    run_command(CMD_START, 8'h00, 1'b0, 0, 0);
    run_command(CMD_WRITE, 8'hFF, 1'b0, 0, 0);          // acknowledged at once
    run_command(CMD_WRITE, 8'h00, 1'b1, 3, 30);         // commands while busy
    run_command(CMD_WRITE, 8'hA5, 1'b0, 7, 0);          // ack on the last poll
    run_command(CMD_WRITE, 8'h5A, 1'b1, 8, 0);          // misses reach the limit
    run_command(CMD_READ,  8'hFF, 1'b1, 0, 0);          // read with ACK
    run_command(CMD_WRITE, 8'h3C, 1'b0, NEVER_ACK, 10); // no device
    run_command(CMD_READ,  8'h00, 1'b0, 0, 20);         // last byte, NACK
    run_command(CMD_STOP,  8'h00, 1'b0, 0, 0);
  endtask

  // One random sequence: mostly complete commands, some noise.
  task automatic random_sequence();
    int kind;
    int ack_after;
    kind      = $urandom_range(0, 99);
    ack_after = ($urandom_range(0, 9) < 2) ? NEVER_ACK : $urandom_range(0, 3);
    if (kind < 12)
      run_command(CMD_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0, 5);
    else if (kind < 24)
      run_command(CMD_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0, 5);
    else if (kind < 54)
      run_command(CMD_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  ack_after, 5);
    else if (kind < 84)
      run_command(CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0, 5);
    else if (kind < 92)
      push_item(random_req(CMD_IDLE));
    else
      push_item(random_req(3'($urandom_range(CMD_READ + 1, 7))));
  endtask

  initial begin
    logic [7:0] limits[4];
    int         goal;
    sb          = new();
    cycles      = 0;
    burst_left  = 0;
    stall_mode  = 0;
    stall_left  = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = CMD_IDLE;
    out_tready  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    limits[0]   = 8'd1;
    limits[1]   = 8'd255;
    limits[2]   = 8'($urandom_range(2, 254));
    limits[3]   = 8'd2;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // write the reset value once so the register is exercised before use
    quiesce_and_set_limit(ACK_LIMIT_RST);
    directed_checks();

    // spread the remaining transfers over the poll limits, at least one
    // sequence under each
    for (int p = 0; p < 4; p++) begin
      quiesce_and_set_limit(limits[p]);
      goal = (ITEMS_TARGET * (p + 1)) / 4;
      do begin
        random_sequence();
      end while (sb.transfers < goal);
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d predicted results never arrived", $time, sb.pending());
    end
    $display("Sent %0d transfers, checked %0d results, poll limits 8, 1, 255, %0d, 2.",
             sb.transfers, sb.results, limits[2]);
    $display("Commands run: %0d start, %0d stop, %0d write (%0d unacknowledged), %0d read.",
             sb.started[CMD_START], sb.started[CMD_STOP], sb.started[CMD_WRITE],
             sb.nacked_writes, sb.started[CMD_READ]);
    if (sb.errors == 0) begin
      $display("i2c_master_byte_engine test passed");
    end else begin
      $display("i2c_master_byte_engine test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/i2cme_pkg.sv
sv/i2cme_in_stage.sv
sv/i2cme_seq.sv
sv/i2cme_out_stage.sv
sv/i2c_master_byte_engine.sv
tb/sv/tb.sv
